// ===== hw/rtl/qmpi_pkg.sv =====
// Shared types and command codes for the prime implicant generator.
// No dependencies.
`default_nettype none
package qmpi_pkg;
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_CLEAR   = 2'd0;
   localparam cmd_type CMD_LOAD    = 2'd1;
   localparam cmd_type CMD_COMPUTE = 2'd2;
   localparam cmd_type CMD_READ    = 2'd3;
endpackage
`default_nettype wire

// ===== hw/rtl/prime_implicant_generator_core.sv =====
// Quine-McCluskey prime implicant generator, top level.
// Depends on qmpi_pkg.
`default_nettype none
// Clear, load and read commands each take one transfer in and give one transfer out; a
// clear or load is accepted on any cycle where the block is idle and the result slot is
// free, a read passes through the pick state because the prime store has a registered
// read port. A compute walks every dash mask m in ascending order: for each set bit of m
// it reads the finished row of level m^bit from the cube row memory, writes the new row,
// then scans its 2^VAR_COUNT term positions one per cycle to append primes to the prime
// store. Every row is written before it is read, so the row memory needs no clearing
// pass. Primes come out in ascending (mask, term) order; beyond PRIME_DEPTH primes the
// rest are dropped and overflow is raised.
module prime_implicant_generator_core #(
   parameter int VAR_COUNT   = 8,
   parameter int PRIME_DEPTH = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire qmpi_pkg::cmd_type req_cmd,
   input  wire logic [7:0]       req_minterm,
   input  wire logic [9:0]       req_pick,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [10:0]           rsp_prime_count,
   output logic [7:0]            rsp_prime_term,
   output logic [7:0]            rsp_prime_mask,
   output logic                  rsp_overflow,
   output logic                  rsp_pick_valid
);
   import qmpi_pkg::*;

   localparam int V  = VAR_COUNT;
   localparam int TS = 1 << V;
   localparam int BW = (V > 1) ? $clog2(V) : 1;
   localparam int CW = $clog2(PRIME_DEPTH + 1);
   localparam int AW = $clog2(PRIME_DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PICK  = 3'd1;
   localparam logic [2:0] ST_BITS  = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_WRITE = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;

   // cube rows: one row per dash mask, bit t set when cube (mask, term t) exists
   logic [TS-1:0]  row_mem [TS];
   logic [TS-1:0]  row_rd_ff;
   logic [2*V-1:0] store_mem [PRIME_DEPTH];
   logic [2*V-1:0] store_rd_ff;

   logic [2:0]     state_ff, state_in;
   logic [TS-1:0]  onset_ff, onset_in;
   logic [TS-1:0]  row_ff, row_in;
   logic [TS-1:0]  prime_ff, prime_in;
   logic [V-1:0]   mask_ff, mask_in;
   logic [V-1:0]   term_ff, term_in;
   logic [BW-1:0]  bit_ff, bit_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           pv_ff, pv_in;
   logic [AW-1:0]  pick_addr;
   logic           take;
   logic           last_bit;
   logic [V-1:0]   bit_vec;
   logic [TS-1:0]  merged;
   logic [TS-1:0]  combined;
   logic           store_we;
   logic           row_we;
   logic [V-1:0]   tv;

   assign take      = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign last_bit  = (bit_ff == BW'(V - 1));
   assign bit_vec   = V'(1) << bit_ff;
   assign pick_addr = AW'(req_pick);

   // pair cubes of the row at mask^bit that differ only in that bit
   always_comb begin
      merged = '0;
      for (int t = 0; t < TS; t++) begin
         tv = V'(t);
         if ((tv & bit_vec) == '0 && (tv & mask_ff) == '0)
            merged[t] = row_rd_ff[t] & row_rd_ff[tv | bit_vec];
      end
   end

   // a cube is combined when a partner one free bit away exists at the same mask
   always_comb begin
      combined = '0;
      for (int t = 0; t < TS; t++) begin
         for (int b = 0; b < V; b++) begin
            if (!mask_ff[b])
               combined[t] = combined[t] | row_ff[V'(t) ^ (V'(1) << b)];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      onset_in     = onset_ff;
      row_in       = row_ff;
      prime_in     = prime_ff;
      mask_in      = mask_ff;
      term_in      = term_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      pv_in        = pv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      store_we     = 1'b0;
      row_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               pv_in = 1'b0;
               case (req_cmd)
                  CMD_CLEAR: begin
                     onset_in     = '0;
                     cnt_in       = '0;
                     ovf_in       = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_LOAD: begin
                     onset_in[V'(req_minterm)] = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_COMPUTE: begin
                     cnt_in   = '0;
                     ovf_in   = 1'b0;
                     mask_in  = '0;
                     row_in   = onset_ff;
                     state_in = ST_WRITE;
                  end
                  default: begin
                     pv_in    = (32'(req_pick) < 32'(cnt_ff));
                     state_in = ST_PICK;
                  end
               endcase
            end
         end
         ST_PICK: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_BITS: begin
            // hold the read address through ST_ACC when this bit is dashed
            if (mask_ff[bit_ff]) begin
               state_in = ST_ACC;
            end else if (last_bit) begin
               state_in = ST_WRITE;
            end else begin
               bit_in = bit_ff + BW'(1);
            end
         end
         ST_ACC: begin
            row_in = row_ff | merged;
            if (last_bit) begin
               state_in = ST_WRITE;
            end else begin
               bit_in   = bit_ff + BW'(1);
               state_in = ST_BITS;
            end
         end
         ST_WRITE: begin
            row_we   = 1'b1;
            prime_in = row_ff & ~combined;
            term_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (prime_ff[term_ff]) begin
               if (cnt_ff < CW'(PRIME_DEPTH)) begin
                  store_we = 1'b1;
                  cnt_in   = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            term_in = term_ff + V'(1);
            if (term_ff == '1) begin
               if (mask_ff == '1) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  mask_in  = mask_ff + V'(1);
                  row_in   = '0;
                  bit_in   = '0;
                  state_in = ST_BITS;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         onset_ff     <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         onset_ff     <= onset_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff   <= row_in;
      prime_ff <= prime_in;
      mask_ff  <= mask_in;
      term_ff  <= term_in;
      bit_ff   <= bit_in;
      pv_ff    <= pv_in;
   end

   // row memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (row_we)
         row_mem[mask_ff] <= row_ff;
      row_rd_ff <= row_mem[mask_ff ^ bit_vec];
   end

   // prime store: append during scan; read by index only when a request is taken,
   // then hold the read data until the result transfer
   always_ff @(posedge clock) begin
      if (store_we)
         store_mem[cnt_ff[AW-1:0]] <= {mask_ff, term_ff};
      if (take)
         store_rd_ff <= store_mem[pick_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = 11'(cnt_ff);
   assign rsp_overflow    = ovf_ff;
   assign rsp_pick_valid  = pv_ff;
   assign rsp_prime_term  = pv_ff ? 8'(store_rd_ff[V-1:0]) : 8'd0;
   assign rsp_prime_mask  = pv_ff ? 8'(store_rd_ff[2*V-1:V]) : 8'd0;
endmodule
`default_nettype wire

// ===== hw/rtl/qmpi_chk.sv =====
// Port-level checker for prime_implicant_generator_core, with its bind.
// Uses no package itself; binds into the top level, which depends on qmpi_pkg.
`default_nettype none
module qmpi_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [10:0] rsp_prime_count,
   input wire logic [7:0]  rsp_prime_term,
   input wire logic [7:0]  rsp_prime_mask,
   input wire logic        rsp_overflow,
   input wire logic        rsp_pick_valid
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");
   a_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pick_valid |-> rsp_prime_count != 11'd0)
      else $error("valid pick with no primes");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pick_valid |-> rsp_prime_term == 8'd0 && rsp_prime_mask == 8'd0)
      else $error("nonzero prime on invalid pick");
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_prime_count != 11'd0)
      else $error("overflow with empty store");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind prime_implicant_generator_core qmpi_chk u_qmpi_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_prime_count(rsp_prime_count), .rsp_prime_term(rsp_prime_term),
   .rsp_prime_mask(rsp_prime_mask), .rsp_overflow(rsp_overflow),
   .rsp_pick_valid(rsp_pick_valid)
);
`default_nettype wire

// ===== tb/sv/prime_implicant_generator_core_tb.sv =====
// Self-checking testbench for prime_implicant_generator_core.
// Depends on qmpi_pkg and the core RTL; a scoreboard class holds a Quine-McCluskey predictor.
`timescale 1ns / 1ps

import qmpi_pkg::*;

typedef struct packed {
   logic [10:0] count;
   logic [7:0]  term;
   logic [7:0]  mask;
   logic        ovf;
   logic        valid;
} prime_rsp_type;

class PrimeScoreboard;
   localparam int DEPTH = 1024;
   bit          onset [256];
   bit          cube_seen [65536];
   bit          merged [65536];
   logic [15:0] prime_list [DEPTH];
   int unsigned found;
   bit          ovf_flag;
   prime_rsp_type pending [$];
   int          errors;
   int          checked;
   int          computes;
   int          valid_reads;

   function new();
      foreach (onset[i]) onset[i] = 0;
      found = 0;
      ovf_flag = 0;
      errors = 0;
      checked = 0;
      computes = 0;
      valid_reads = 0;
   endfunction

   // Rebuild all cubes level by level, then collect unmerged cubes in (mask, term) order.
   function void build_primes();
      logic [7:0]  bitv;
      logic [15:0] here;
      logic [15:0] there;
      foreach (cube_seen[i]) begin
         cube_seen[i] = 0;
         merged[i] = 0;
      end
      for (int t = 0; t < 256; t++) cube_seen[t] = onset[t];
      for (int m = 0; m < 256; m++) begin
         for (int t = 0; t < 256; t++) begin
            if ((t & m) != 0) continue;
            here = {m[7:0], t[7:0]};
            if (!cube_seen[here]) continue;
            for (int b = 0; b < 8; b++) begin
               bitv = 8'd1 << b;
               if (((m | t) & bitv) != 0) continue;
               there = {m[7:0], t[7:0] | bitv};
               if (cube_seen[there]) begin
                  merged[here] = 1;
                  merged[there] = 1;
                  cube_seen[{m[7:0] | bitv, t[7:0]}] = 1;
               end
            end
         end
      end
      found = 0;
      ovf_flag = 0;
      for (int m = 0; m < 256; m++) begin
         for (int t = 0; t < 256; t++) begin
            if ((t & m) != 0) continue;
            here = {m[7:0], t[7:0]};
            if (!cube_seen[here] || merged[here]) continue;
            if (found < DEPTH) begin
               prime_list[found] = here;
               found++;
            end else begin
               ovf_flag = 1;
            end
         end
      end
   endfunction

   function void note_request(cmd_type cmd, logic [7:0] minterm, logic [9:0] pick);
      prime_rsp_type r;
      r = '0;
      case (cmd)
         CMD_CLEAR: begin
            foreach (onset[i]) onset[i] = 0;
            found = 0;
            ovf_flag = 0;
         end
         CMD_LOAD: onset[minterm] = 1;
         CMD_COMPUTE: begin
            build_primes();
            computes++;
         end
         default: begin
            if (pick < found) begin
               r.valid = 1;
               r.mask = prime_list[pick][15:8];
               r.term = prime_list[pick][7:0];
               valid_reads++;
            end
         end
      endcase
      r.count = found[10:0];
      r.ovf = ovf_flag;
      pending = {pending, r};
   endfunction

   function void check_response(prime_rsp_type got);
      prime_rsp_type want;
      checked++;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %p", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.count !== want.count)
         $display("%0t: prime_count exp %0d got %0d", $time, want.count, got.count);
      if (got.term !== want.term)
         $display("%0t: prime_term exp %h got %h", $time, want.term, got.term);
      if (got.mask !== want.mask)
         $display("%0t: prime_mask exp %h got %h", $time, want.mask, got.mask);
      if (got.ovf !== want.ovf)
         $display("%0t: overflow exp %0b got %0b", $time, want.ovf, got.ovf);
      if (got.valid !== want.valid)
         $display("%0t: pick_valid exp %0b got %0b", $time, want.valid, got.valid);
      if (got !== want) errors++;
   endfunction
endclass

module prime_implicant_generator_core_tb;
   localparam int WATCHDOG_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   cmd_type     req_cmd;
   logic [7:0]  req_minterm;
   logic [9:0]  req_pick;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [10:0] rsp_prime_count;
   logic [7:0]  rsp_prime_term;
   logic [7:0]  rsp_prime_mask;
   logic        rsp_overflow;
   logic        rsp_pick_valid;

   PrimeScoreboard sb;

   int  send_idle_pct;   // chance in a hundred that the sender idles before a transfer
   int  rsp_stall_pct;   // chance in a hundred that the receiver stalls
   bit  hold_off;        // receiver long hold-off request
   int  sent;
   int  idle_count;

   prime_implicant_generator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_minterm(req_minterm), .req_pick(req_pick),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_prime_count(rsp_prime_count), .rsp_prime_term(rsp_prime_term),
      .rsp_prime_mask(rsp_prime_mask), .rsp_overflow(rsp_overflow),
      .rsp_pick_valid(rsp_pick_valid)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Offer one request; drop valid only for the idle gap, then hold it until the transfer.
   task automatic send_req(cmd_type cmd, logic [7:0] minterm, logic [9:0] pick);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_minterm <= minterm;
      req_pick    <= pick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, minterm, pick);
      sent++;
   endtask

   // Hold the sender until every expected response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Pick an idle mix for one phase of the random part.
   task automatic set_phase(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 79; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 79; end
         default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
      endcase
   endtask

   // One well-formed function: clear, load a random on-set, compute, read primes back.
   task automatic run_function(int loads, int reads);
      int cnt;
      send_req(CMD_CLEAR, 8'($urandom), 10'($urandom));
      for (int i = 0; i < loads; i++) send_req(CMD_LOAD, 8'($urandom), 10'($urandom));
      send_req(CMD_COMPUTE, 8'($urandom), 10'($urandom));
      cnt = sb.found;
      for (int i = 0; i < reads; i++) begin
         if (cnt > 0 && $urandom_range(9) < 8)
            send_req(CMD_READ, 8'($urandom), 10'($urandom_range(cnt - 1)));
         else
            send_req(CMD_READ, 8'($urandom), 10'($urandom));
      end
   endtask

   // Receiver: check each response transfer, then pick next cycle's ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_prime_count, rsp_prime_term, rsp_prime_mask,
                               rsp_overflow, rsp_pick_valid});
         rsp_ready <= !hold_off && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Long hold-off, counted here, so the sender backs up against the block.
   initial begin
      hold_off = 0;
      wait (sent >= 40);
      @(posedge clock);
      hold_off <= 1;
      repeat (300) @(posedge clock);
      hold_off <= 0;
   end

   // Watchdog: restart on any transfer, give up after a long quiet stretch.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", sb.pending.size());
         $display("prime_implicant_generator_core_tb NOT OK");
         $finish;
      end
   end

   initial begin
      sb = new();
      sent = 0;
      idle_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset = 1;
      req_valid = 0;
      req_cmd = CMD_CLEAR;
      req_minterm = '0;
      req_pick = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reads after reset, empty on-set, field extremes, duplicates.
      send_req(CMD_READ, 8'h00, 10'd0);
      send_req(CMD_READ, 8'hff, 10'd1023);
      send_req(CMD_COMPUTE, 8'h00, 10'd0);
      send_req(CMD_READ, 8'h00, 10'd0);
      send_req(CMD_LOAD, 8'h00, 10'd1023);
      send_req(CMD_LOAD, 8'hff, 10'd0);
      send_req(CMD_LOAD, 8'hff, 10'd0);
      send_req(CMD_LOAD, 8'h01, 10'd0);
      send_req(CMD_LOAD, 8'h7f, 10'd0);
      send_req(CMD_COMPUTE, 8'hff, 10'd1023);
      send_req(CMD_READ, 8'h00, 10'd0);
      send_req(CMD_READ, 8'h00, 10'd1);
      send_req(CMD_READ, 8'h00, 10'd2);
      send_req(CMD_READ, 8'h00, 10'd1023);
      send_req(CMD_CLEAR, 8'hff, 10'd1023);
      send_req(CMD_READ, 8'h00, 10'd0);
      // Four minterms over the two top bits collapse to one two-dash prime.
      for (int i = 0; i < 256; i += 64) send_req(CMD_LOAD, 8'(i), 10'd0);
      send_req(CMD_COMPUTE, 8'h00, 10'd0);
      send_req(CMD_READ, 8'h00, 10'd0);
      send_req(CMD_READ, 8'h00, 10'd1);
      drain();

      // Random functions; onset sizes vary to spread prime counts.
      for (int s = 0; s < 10; s++) begin
         set_phase(s);
         run_function($urandom_range(1, 40), $urandom_range(10, 25));
         // Noise: loads, clears and reads against the current state.
         for (int i = 0; i < 8; i++)
            send_req(cmd_type'($urandom_range(2) == 2 ? CMD_READ : $urandom_range(1)),
                     8'($urandom), 10'($urandom));
         if (s == 3) drain();
      end
      drain();

      repeat (50) @(posedge clock);
      $display("covered %0d requests, %0d responses, %0d computes, %0d in-range reads",
               sent, sb.checked, sb.computes, sb.valid_reads);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("prime_implicant_generator_core_tb OK");
      else
         $display("prime_implicant_generator_core_tb NOT OK");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/qmpi_pkg.sv
hw/rtl/prime_implicant_generator_core.sv
hw/rtl/qmpi_chk.sv
tb/sv/prime_implicant_generator_core_tb.sv
